/* hw/rtl/p128_pkg.sv */
// Shared constants, tables, codes and controller/datapath types for the PRESENT-128 core.
package p128_pkg;

  localparam int unsigned ROUNDS    = 31;
  localparam int unsigned NUM_KEYS  = ROUNDS + 1;
  localparam int unsigned KW        = $clog2(NUM_KEYS);
  localparam int unsigned BLOCK_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE    = 2'd2;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  typedef enum logic [1:0] {
    ACT_ENCRYPT = 2'd0,
    ACT_DECRYPT = 2'd1,
    ACT_CTR     = 2'd2
  } p128_action_e;

  typedef enum logic [2:0] {
    ST_KEY_LOAD,
    ST_KEY_EXPAND,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } p128_state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_KEY_LOAD,
    OP_KEY_STEP,
    OP_LOAD,
    OP_ENC_ROUND,
    OP_DEC_ROUND,
    OP_ADD_KEY
  } p128_op_e;

  typedef struct packed {
    p128_op_e        op;
    logic [KW-1:0]   key_idx;
    logic [KW-1:0]   rd_addr;
    logic            out_load;
  } p128_cmd_t;

  typedef struct packed {
    logic key_wr;
    logic item_dec;
  } p128_status_t;

endpackage

/* hw/rtl/p128_ctrl.sv */
// Sequencer for key expansion, round iteration and result handoff.
module p128_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             action_i,
  input  logic                   out_stall_i,
  input  p128_pkg::p128_status_t status_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output p128_pkg::p128_cmd_t    cmd_o
);

  p128_pkg::p128_state_e       state_q, state_d;
  logic [p128_pkg::KW-1:0]     step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        take_ok;
  logic                        accept;
  logic                        last_step;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign take_ok   = !status_i.key_wr &&
                     ((state_q == p128_pkg::ST_IDLE) ||
                      ((state_q == p128_pkg::ST_FINISH) && out_free));
  assign accept    = in_valid_i && take_ok;
  assign last_step = (step_q == p128_pkg::KW'(p128_pkg::ROUNDS));

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    if (status_i.key_wr) begin
      state_d = p128_pkg::ST_KEY_LOAD;
      step_d  = '0;
    end else begin
      unique case (state_q)
        p128_pkg::ST_KEY_LOAD: begin
          state_d = p128_pkg::ST_KEY_EXPAND;
          step_d  = '0;
        end
        p128_pkg::ST_KEY_EXPAND: begin
          if (last_step) begin
            state_d = p128_pkg::ST_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        p128_pkg::ST_IDLE: begin
          if (accept) begin
            state_d = p128_pkg::ST_RUN;
            step_d  = '0;
          end
        end
        p128_pkg::ST_RUN: begin
          if (last_step) begin
            state_d = p128_pkg::ST_FINISH;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        p128_pkg::ST_FINISH: begin
          if (accept) begin
            state_d = p128_pkg::ST_RUN;
            step_d  = '0;
          end else if (out_free) begin
            state_d = p128_pkg::ST_IDLE;
          end
        end
        default: begin
          state_d = p128_pkg::ST_KEY_LOAD;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = p128_pkg::OP_IDLE;
    cmd_o.key_idx  = step_q;
    cmd_o.rd_addr  = '0;
    cmd_o.out_load = (state_q == p128_pkg::ST_FINISH) && out_free;
    unique case (state_q)
      p128_pkg::ST_KEY_LOAD:   cmd_o.op = p128_pkg::OP_KEY_LOAD;
      p128_pkg::ST_KEY_EXPAND: cmd_o.op = p128_pkg::OP_KEY_STEP;
      p128_pkg::ST_RUN: begin
        if (status_i.item_dec) begin
          cmd_o.op      = (step_q == '0) ? p128_pkg::OP_ADD_KEY : p128_pkg::OP_DEC_ROUND;
          cmd_o.rd_addr = p128_pkg::KW'(p128_pkg::ROUNDS - 1) - step_q;
        end else begin
          cmd_o.op      = last_step ? p128_pkg::OP_ADD_KEY : p128_pkg::OP_ENC_ROUND;
          cmd_o.rd_addr = step_q + 1'b1;
        end
      end
      default: begin
        if (accept) begin
          cmd_o.op = p128_pkg::OP_LOAD;
        end
        // fetch the first round key for the item being taken
        cmd_o.rd_addr = (action_i == p128_pkg::ACT_DECRYPT) ?
                        p128_pkg::KW'(p128_pkg::ROUNDS) : '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= p128_pkg::ST_KEY_LOAD;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !take_ok;
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/p128_datapath.sv */
// Key registers, round key memory, key schedule, round logic, counter and output register.
module p128_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  p128_pkg::p128_cmd_t               cmd_i,
  input  logic                              cfg_valid_i,
  input  logic [p128_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [p128_pkg::BLOCK_W-1:0]      cfg_data_i,
  input  logic [1:0]                        action_i,
  input  logic [p128_pkg::BLOCK_W-1:0]      data_in_i,
  input  logic                              message_start_i,
  input  logic [3:0]                        valid_bytes_i,
  output p128_pkg::p128_status_t            status_o,
  output logic [p128_pkg::BLOCK_W-1:0]      data_out_o
);

  function automatic logic [63:0] sub_fwd(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = p128_pkg::SBOX_FWD[s[4*i +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_inv(input logic [63:0] s);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = p128_pkg::SBOX_INV[s[4*i +: 4]];
    end
    return r;
  endfunction

  // bit i moves to 16*i mod 63 (bit 63 stays put), which is {i[1:0], i[5:2]}
  function automatic logic [63:0] perm_fwd(input logic [63:0] s);
    logic [63:0] r;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(i);
      r[{idx[1:0], idx[5:2]}] = s[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_inv(input logic [63:0] s);
    logic [63:0] r;
    logic [5:0]  idx;
    for (int i = 0; i < 64; i++) begin
      idx = 6'(i);
      r[i] = s[{idx[1:0], idx[5:2]}];
    end
    return r;
  endfunction

  logic [63:0] key_high_q, key_low_q, nonce_q, ctr_q;
  logic [63:0] kh_q, kl_q, kh_d, kl_d;
  logic [63:0] rkey_mem [p128_pkg::NUM_KEYS];
  logic [63:0] rk_q;
  logic [63:0] s_q, s_d;
  logic [63:0] data_q;
  logic [63:0] data_out_q;
  logic [63:0] ctr_base;
  logic [63:0] mask;
  logic [63:0] result;
  logic [63:0] rot_h, rot_l;
  logic [4:0]  rcon;
  logic [4:0]  mix;
  logic [3:0]  nbytes_q;
  p128_pkg::p128_action_e action_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      nonce_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        p128_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        p128_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        p128_pkg::REG_NONCE:    nonce_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status_o.key_wr   = cfg_valid_i &&
                             ((cfg_index_i == p128_pkg::REG_KEY_HIGH) ||
                              (cfg_index_i == p128_pkg::REG_KEY_LOW));
  assign status_o.item_dec = (action_q == p128_pkg::ACT_DECRYPT);

  // Key schedule: rotate the 128-bit register left by 61, S-box the top two
  // nibbles, fold the round counter into bits 66..62.
  always_comb begin
    rot_h = {kh_q[2:0], kl_q[63:3]};
    rot_l = {kl_q[2:0], kh_q[63:3]};
    rcon  = 5'(cmd_i.key_idx) + 5'd1;
    kh_d  = rot_h;
    kl_d  = rot_l;
    kh_d[63:60] = p128_pkg::SBOX_FWD[rot_h[63:60]];
    kh_d[59:56] = p128_pkg::SBOX_FWD[rot_h[59:56]];
    mix = {kh_d[2:0], rot_l[63:62]} ^ rcon;
    kh_d[2:0]   = mix[4:2];
    kl_d[63:62] = mix[1:0];
    unique case (cmd_i.op)
      p128_pkg::OP_KEY_LOAD: begin
        kh_d = key_high_q;
        kl_d = key_low_q;
      end
      p128_pkg::OP_KEY_STEP: ;
      default: begin
        kh_d = kh_q;
        kl_d = kl_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    kh_q <= kh_d;
    kl_q <= kl_d;
  end

  // Round key memory: one write port for expansion, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == p128_pkg::OP_KEY_STEP) begin
      rkey_mem[cmd_i.key_idx] <= kh_q;
    end
    rk_q <= rkey_mem[cmd_i.rd_addr];
  end

  assign ctr_base = message_start_i ? '0 : ctr_q;

  // Block counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if ((cmd_i.op == p128_pkg::OP_LOAD) && (action_i == p128_pkg::ACT_CTR)) begin
      ctr_q <= ctr_base + 64'd1;
    end
  end

  // Round datapath
  always_comb begin
    s_d = s_q;
    unique case (cmd_i.op)
      p128_pkg::OP_LOAD: begin
        s_d = (action_i == p128_pkg::ACT_CTR) ? (nonce_q + ctr_base) : data_in_i;
      end
      p128_pkg::OP_ENC_ROUND: s_d = perm_fwd(sub_fwd(s_q ^ rk_q));
      p128_pkg::OP_DEC_ROUND: s_d = sub_inv(perm_inv(s_q)) ^ rk_q;
      p128_pkg::OP_ADD_KEY:   s_d = s_q ^ rk_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (cmd_i.op == p128_pkg::OP_LOAD) begin
      data_q   <= data_in_i;
      action_q <= p128_pkg::p128_action_e'(action_i);
      nbytes_q <= valid_bytes_i;
    end
  end

  // Byte mask for CTR: counts above eight cover the whole block
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask[8*j +: 8] = {8{nbytes_q > 4'(j)}};
    end
  end

  always_comb begin
    unique case (action_q)
      p128_pkg::ACT_ENCRYPT,
      p128_pkg::ACT_DECRYPT: result = s_q;
      p128_pkg::ACT_CTR:     result = data_q ^ (s_q & mask);
      default:               result = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      data_out_q <= result;
    end
  end

  assign data_out_o = data_out_q;

endmodule

/* hw/rtl/present128_cipher_ctr.sv */
// PRESENT-128 block cipher with encrypt, decrypt and CTR operations: top level.
//
// Input channel: in_valid_i / in_stall_o with action_i, data_in_i, message_start_i and
// valid_bytes_i; a transfer takes place when valid is high and stall is low. Output
// channel: out_valid_o / out_stall_i with data_out_o. Config channel: cfg_valid_i /
// cfg_ready_o with cfg_index_i (0 key high, 1 key low, 2 nonce) and cfg_data_i.
// One item is in the round loop at a time. After the input transfer the round unit
// runs 31 rounds plus the final key add, one round key read per cycle from the round
// key memory, then the handoff state loads the output register; no new item is taken
// before the result of the last one is loaded.
// The output register decouples the sides: the next item is taken in the cycle the
// result is loaded, and while the receiver stalls the finished result waits in the
// handoff state and the input stays stalled.
// After reset, and after each key register write, the key schedule runs (one load plus
// one round key per cycle) with the input stalled. The block counter resets to zero,
// restarts from zero at a message start and advances on each CTR item.
module present128_cipher_ctr (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [p128_pkg::BLOCK_W-1:0]      data_in_i,
  input  logic                              message_start_i,
  input  logic [3:0]                        valid_bytes_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [p128_pkg::BLOCK_W-1:0]      data_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [p128_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [p128_pkg::BLOCK_W-1:0]      cfg_data_i
);

  p128_pkg::p128_cmd_t    cmd;
  p128_pkg::p128_status_t status;

  assign cfg_ready_o = 1'b1;

  p128_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  p128_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .data_in_i       (data_in_i),
    .message_start_i (message_start_i),
    .valid_bytes_i   (valid_bytes_i),
    .status_o        (status),
    .data_out_o      (data_out_o)
  );

  // An accepted item starts the round loop in the next cycle
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=>
      (cmd.op == p128_pkg::OP_ENC_ROUND || cmd.op == p128_pkg::OP_ADD_KEY))
    else $error("accepted item did not enter the round loop");

  // No item is taken while round keys are being expanded
  a_no_accept_in_expand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == p128_pkg::OP_KEY_LOAD || cmd.op == p128_pkg::OP_KEY_STEP) |-> in_stall_o)
    else $error("input taken during key expansion");

  // A result load never overwrites a result still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // A new result appears only after a load from the round unit
  a_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule

/* tb/sv/tb_present128_cipher_ctr.sv */
// Self-checking testbench for present128_cipher_ctr with its own PRESENT-128 and CTR predictor.
module tb_present128_cipher_ctr;

  localparam logic [1:0]                     ACT_RESERVED  = 2'd3;
  localparam logic [p128_pkg::CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
  localparam int unsigned                    CIPHER_ROUNDS = 31;
  localparam int unsigned                    LONG_HOLD     = 300;

  localparam logic [3:0] FWD_NIB [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] INV_NIB [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] data;
    logic        start;
    logic [3:0]  nbytes;
  } cipher_req_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     action_i        = '0;
  logic [p128_pkg::BLOCK_W-1:0]   data_in_i       = '0;
  logic                           message_start_i = 1'b0;
  logic [3:0]                     valid_bytes_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [p128_pkg::BLOCK_W-1:0]   data_out_o;
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [p128_pkg::CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [p128_pkg::BLOCK_W-1:0]   cfg_data_i      = '0;

  // predictor state
  logic [63:0] key_hi_q, key_lo_q, nonce_q, keystream_index;
  logic [63:0] sched_keys [CIPHER_ROUNDS+1];

  cipher_req_t pending_reqs [$];
  logic [63:0] expected_blocks [$];
  cipher_req_t cur_req;

  int unsigned error_count = 0;
  int unsigned n_encrypt = 0, n_decrypt = 0, n_ctr = 0, n_spare = 0;
  int unsigned n_results = 0, n_reg_writes = 0;
  int unsigned sender_idle_pct = 0, recv_idle_pct = 0;
  int unsigned gap_left = 0, stall_left = 0;
  int unsigned long_hold_req = 0, long_hold_ack = 0;

  present128_cipher_ctr dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .data_in_i       (data_in_i),
    .message_start_i (message_start_i),
    .valid_bytes_i   (valid_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_out_o      (data_out_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] sbox_layer(input logic [63:0] s, input bit inverse);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = inverse ? INV_NIB[s[4*i +: 4]] : FWD_NIB[s[4*i +: 4]];
    end
    return r;
  endfunction

  // bit i moves to 16*i mod 63, bit 63 stays put
  function automatic logic [63:0] bit_perm(input logic [63:0] s, input bit inverse);
    logic [63:0] r;
    int unsigned dst;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      dst = (i == 63) ? 63 : (16 * i) % 63;
      if (inverse) r[i] = s[dst];
      else r[dst] = s[i];
    end
    return r;
  endfunction

  function automatic void expand_schedule();
    logic [127:0] k;
    k = {key_hi_q, key_lo_q};
    sched_keys[0] = k[127:64];
    for (int i = 1; i <= CIPHER_ROUNDS; i++) begin
      k = {k[66:0], k[127:67]};
      k[127:124] = FWD_NIB[k[127:124]];
      k[123:120] = FWD_NIB[k[123:120]];
      k[66:62] = k[66:62] ^ 5'(i);
      sched_keys[i] = k[127:64];
    end
  endfunction

  function automatic logic [63:0] present_encrypt(input logic [63:0] s);
    for (int r = 0; r < CIPHER_ROUNDS; r++) s = bit_perm(sbox_layer(s ^ sched_keys[r], 0), 0);
    return s ^ sched_keys[CIPHER_ROUNDS];
  endfunction

  function automatic logic [63:0] present_decrypt(input logic [63:0] s);
    s = s ^ sched_keys[CIPHER_ROUNDS];
    for (int r = CIPHER_ROUNDS - 1; r >= 0; r--)
      s = sbox_layer(bit_perm(s, 1), 1) ^ sched_keys[r];
    return s;
  endfunction

  // result of one block; CTR blocks advance the CTR block index
  function automatic logic [63:0] cipher_out(input cipher_req_t req);
    logic [63:0] ks, mask;
    int unsigned n;
    case (req.action)
      p128_pkg::ACT_ENCRYPT: return present_encrypt(req.data);
      p128_pkg::ACT_DECRYPT: return present_decrypt(req.data);
      p128_pkg::ACT_CTR: begin
        if (req.start) keystream_index = '0;
        ks = present_encrypt(nonce_q + keystream_index);
        keystream_index = keystream_index + 64'd1;
        n = (req.nbytes > 8) ? 8 : req.nbytes;
        mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        return req.data ^ (ks & mask);
      end
      default: return req.data;
    endcase
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 40);
    return $urandom_range(41, 120);
  endfunction

  function automatic logic [63:0] random_block();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic queue_req(input logic [1:0] act, input logic [63:0] data,
                           input logic start, input logic [3:0] nbytes);
    pending_reqs.push_back('{action: act, data: data, start: start, nbytes: nbytes});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_blocks.size() != 0);
  endtask

  task automatic write_reg(input logic [p128_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_reg_writes++;
    case (idx)
      p128_pkg::REG_KEY_HIGH: begin
        key_hi_q = value;
        expand_schedule();
      end
      p128_pkg::REG_KEY_LOW: begin
        key_lo_q = value;
        expand_schedule();
      end
      p128_pkg::REG_NONCE: nonce_q = value;
      default: ;
    endcase
  endtask

  // sender: offer queued blocks, hold each until transferred
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_blocks.push_back(cipher_out(cur_req));
        case (cur_req.action)
          p128_pkg::ACT_ENCRYPT: n_encrypt++;
          p128_pkg::ACT_DECRYPT: n_decrypt++;
          p128_pkg::ACT_CTR:     n_ctr++;
          default:               n_spare++;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          action_i        <= cur_req.action;
          data_in_i       <= cur_req.data;
          message_start_i <= cur_req.start;
          valid_bytes_i   <= cur_req.nbytes;
          in_valid_i      <= 1'b1;
          if ($urandom_range(99) < sender_idle_pct) gap_left = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          $error("data_out: no block expected, got %h", data_out_o);
          error_count++;
        end else begin
          want = expected_blocks.pop_front();
          n_results++;
          if (data_out_o !== want) begin
            $error("data_out mismatch: expected %h, actual %h", want, data_out_o);
            error_count++;
          end
        end
      end
      if (long_hold_ack != long_hold_req) begin
        long_hold_ack = long_hold_req;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(99) < recv_idle_pct) begin
        stall_left = idle_len();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin : stimulus
    int unsigned phase, items, chunk, r, len;
    bit held;
    logic [63:0] khi, klo, nce;
    key_hi_q = '0;
    key_lo_q = '0;
    nonce_q = '0;
    keystream_index = '0;
    expand_schedule();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset keys: extremes, every operation, odd byte counts, reserved code
    queue_req(p128_pkg::ACT_ENCRYPT, '0, 1'b0, 4'd8);
    queue_req(p128_pkg::ACT_ENCRYPT, '1, 1'b1, 4'd15);
    queue_req(p128_pkg::ACT_DECRYPT, '0, 1'b0, 4'd0);
    queue_req(p128_pkg::ACT_DECRYPT, '1, 1'b1, 4'd8);
    queue_req(p128_pkg::ACT_CTR, '0, 1'b1, 4'd8);
    queue_req(p128_pkg::ACT_CTR, random_block(), 1'b0, 4'd1);
    queue_req(p128_pkg::ACT_CTR, random_block(), 1'b0, 4'd0);
    queue_req(p128_pkg::ACT_CTR, random_block(), 1'b0, 4'd9);
    queue_req(p128_pkg::ACT_CTR, '1, 1'b0, 4'd15);
    queue_req(ACT_RESERVED, random_block(), 1'b1, 4'd8);
    queue_req(p128_pkg::ACT_CTR, random_block(), 1'b0, 4'd7);
    wait_drained();

    // all-ones key and nonce: CTR input wraps past zero
    write_reg(p128_pkg::REG_KEY_HIGH, '1);
    write_reg(p128_pkg::REG_KEY_LOW, '1);
    write_reg(p128_pkg::REG_NONCE, '1);
    write_reg(REG_SPARE, {$urandom, $urandom});
    queue_req(p128_pkg::ACT_ENCRYPT, '0, 1'b0, 4'd1);
    queue_req(p128_pkg::ACT_ENCRYPT, '1, 1'b0, 4'd8);
    queue_req(p128_pkg::ACT_DECRYPT, '1, 1'b0, 4'd8);
    queue_req(p128_pkg::ACT_CTR, '0, 1'b1, 4'd8);
    queue_req(p128_pkg::ACT_CTR, '0, 1'b0, 4'd8);
    queue_req(p128_pkg::ACT_CTR, '1, 1'b0, 4'd4);
    queue_req(ACT_RESERVED, '1, 1'b0, 4'd15);
    queue_req(p128_pkg::ACT_CTR, random_block(), 1'b1, 4'd1);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin khi = '0; klo = '0; nce = 64'hFFFF_FFFF_FFFF_FFFC; end
        1: begin khi = '1; klo = '1; nce = '0; end
        2: begin khi = '1; klo = '0; nce = {$urandom, $urandom}; end
        default: begin khi = {$urandom, $urandom}; klo = {$urandom, $urandom};
                       nce = {$urandom, $urandom}; end
      endcase
      write_reg(p128_pkg::REG_KEY_HIGH, khi);
      write_reg(p128_pkg::REG_KEY_LOW, klo);
      write_reg(p128_pkg::REG_NONCE, nce);
      // alternate: no idling, sender only, receiver only, both
      sender_idle_pct = (phase % 4 == 1 || phase % 4 == 3) ? 30 : 0;
      recv_idle_pct   = (phase % 4 == 2 || phase % 4 == 3) ? 25 : 0;
      held = 1'b0;
      items = 0;
      while (items < 185) begin
        chunk = $urandom_range(20, 80);
        repeat (chunk) begin
          r = $urandom_range(99);
          if (r < 45) begin
            // well-formed message: full blocks, then a tail of one to eight bytes
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
              queue_req(p128_pkg::ACT_CTR, random_block(), k == 0,
                        (k == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8);
            end
            items += len;
          end else begin
            if (r < 65) queue_req(p128_pkg::ACT_ENCRYPT, random_block(), 1'($urandom),
                                  4'($urandom));
            else if (r < 80) queue_req(p128_pkg::ACT_DECRYPT, random_block(), 1'($urandom),
                                       4'($urandom));
            else if (r < 88) queue_req(p128_pkg::ACT_DECRYPT,
                                       present_encrypt(random_block()),
                                       1'($urandom), 4'($urandom));
            else if (r < 94) queue_req(p128_pkg::ACT_CTR, random_block(), 1'($urandom),
                                       4'($urandom));
            else queue_req(ACT_RESERVED, random_block(), 1'($urandom), 4'($urandom));
            items++;
          end
        end
        // hold off the receiver while blocks keep coming
        if (phase % 4 == 3 && !held) begin
          long_hold_req++;
          held = 1'b1;
        end
        if ($urandom_range(99) < 30) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d encrypt, %0d decrypt, %0d CTR and %0d reserved-code blocks,",
             n_encrypt, n_decrypt, n_ctr, n_spare);
    $display("%0d results checked across %0d register writes", n_results, n_reg_writes);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/p128_pkg.sv
hw/rtl/p128_ctrl.sv
hw/rtl/p128_datapath.sv
hw/rtl/present128_cipher_ctr.sv
tb/sv/tb_present128_cipher_ctr.sv
